@@ src/sha_pkg.sv @@
// SHA-256 shared types, constants and bit functions.
// Used by sha_round, the sha256_stream_hasher top level and its testbench. No dependencies.
package sha_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [7:0] vars_t;   // index 0 is a / H0, index 7 is h / H7

    localparam vars_t H_INIT = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam word_t PAD_WORD = 32'h8000_0000;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t round_k(input logic [5:0] r);
        case (r)
            6'd0:  round_k = 32'h428A2F98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hB5C0FBCF;
            6'd3:  round_k = 32'hE9B5DBA5;
            6'd4:  round_k = 32'h3956C25B;
            6'd5:  round_k = 32'h59F111F1;
            6'd6:  round_k = 32'h923F82A4;
            6'd7:  round_k = 32'hAB1C5ED5;
            6'd8:  round_k = 32'hD807AA98;
            6'd9:  round_k = 32'h12835B01;
            6'd10: round_k = 32'h243185BE;
            6'd11: round_k = 32'h550C7DC3;
            6'd12: round_k = 32'h72BE5D74;
            6'd13: round_k = 32'h80DEB1FE;
            6'd14: round_k = 32'h9BDC06A7;
            6'd15: round_k = 32'hC19BF174;
            6'd16: round_k = 32'hE49B69C1;
            6'd17: round_k = 32'hEFBE4786;
            6'd18: round_k = 32'h0FC19DC6;
            6'd19: round_k = 32'h240CA1CC;
            6'd20: round_k = 32'h2DE92C6F;
            6'd21: round_k = 32'h4A7484AA;
            6'd22: round_k = 32'h5CB0A9DC;
            6'd23: round_k = 32'h76F988DA;
            6'd24: round_k = 32'h983E5152;
            6'd25: round_k = 32'hA831C66D;
            6'd26: round_k = 32'hB00327C8;
            6'd27: round_k = 32'hBF597FC7;
            6'd28: round_k = 32'hC6E00BF3;
            6'd29: round_k = 32'hD5A79147;
            6'd30: round_k = 32'h06CA6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27B70A85;
            6'd33: round_k = 32'h2E1B2138;
            6'd34: round_k = 32'h4D2C6DFC;
            6'd35: round_k = 32'h53380D13;
            6'd36: round_k = 32'h650A7354;
            6'd37: round_k = 32'h766A0ABB;
            6'd38: round_k = 32'h81C2C92E;
            6'd39: round_k = 32'h92722C85;
            6'd40: round_k = 32'hA2BFE8A1;
            6'd41: round_k = 32'hA81A664B;
            6'd42: round_k = 32'hC24B8B70;
            6'd43: round_k = 32'hC76C51A3;
            6'd44: round_k = 32'hD192E819;
            6'd45: round_k = 32'hD6990624;
            6'd46: round_k = 32'hF40E3585;
            6'd47: round_k = 32'h106AA070;
            6'd48: round_k = 32'h19A4C116;
            6'd49: round_k = 32'h1E376C08;
            6'd50: round_k = 32'h2748774C;
            6'd51: round_k = 32'h34B0BCB5;
            6'd52: round_k = 32'h391C0CB3;
            6'd53: round_k = 32'h4ED8AA4A;
            6'd54: round_k = 32'h5B9CCA4F;
            6'd55: round_k = 32'h682E6FF3;
            6'd56: round_k = 32'h748F82EE;
            6'd57: round_k = 32'h78A5636F;
            6'd58: round_k = 32'h84C87814;
            6'd59: round_k = 32'h8CC70208;
            6'd60: round_k = 32'h90BEFFFA;
            6'd61: round_k = 32'hA4506CEB;
            6'd62: round_k = 32'hBEF9A3F7;
            default: round_k = 32'hC67178F2;
        endcase
    endfunction

endpackage

@@ src/sha_in_if.sv @@
// Input channel of the SHA-256 hasher: one message word per handshake.
// Depends on nothing.
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        end_of_message;

    modport source (output valid, data_word, valid_bytes, end_of_message, input ready);
    modport sink   (input valid, data_word, valid_bytes, end_of_message, output ready);
endinterface

@@ src/sha_out_if.sv @@
// Output channel of the SHA-256 hasher: one digest word per handshake.
// Depends on nothing.
interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;

    modport source (output valid, digest_word, word_index, digest_done, input ready);
    modport sink   (input valid, digest_word, word_index, digest_done, output ready);
endinterface

@@ src/sha_round.sv @@
// One SHA-256 round plus the next message schedule word, combinational.
// Depends on sha_pkg.
module sha_round
    import sha_pkg::*;
(
    input  vars_t vars,
    input  word_t k,
    input  word_t w0,
    input  word_t w1,
    input  word_t w9,
    input  word_t w14,
    output vars_t vars_new,
    output word_t w_new
);

    word_t t1;
    word_t t2;
    word_t ch;
    word_t maj;

    always_comb
    begin
        ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
        maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
        t1  = vars[7] + big_sigma1(vars[4]) + ch + k + w0;
        t2  = big_sigma0(vars[0]) + maj;

        vars_new[7] = vars[6];
        vars_new[6] = vars[5];
        vars_new[5] = vars[4];
        vars_new[4] = vars[3] + t1;
        vars_new[3] = vars[2];
        vars_new[2] = vars[1];
        vars_new[1] = vars[0];
        vars_new[0] = t1 + t2;

        // W[r+16], shifted in behind the window
        w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
    end

endmodule

@@ src/sha256_stream_hasher.sv @@
// SHA-256 stream hasher top level: word intake, padding sequencer, round loop.
// Depends on sha_pkg, sha_in_if, sha_out_if and sha_round.
//
// A message word is taken in any cycle in which the input is ready. The word
// that completes a 16-word block starts a compression with the input not
// ready: 64 rounds through the single round unit, one round per cycle, then
// the hash update. The end-of-message word starts the padding sequence, which
// pushes one padding word per cycle up to the length words and runs one or two
// compressions; the eight digest words then go out one per accepted handshake,
// H0 first. The input is not ready during a compression, and from the
// end-of-message word until the last digest word has been taken.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha_in_if.sink       msg,
    sha_out_if.source    digest
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TAIL  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_HADD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // padding progress
    localparam logic [2:0] TL_NONE = 3'd0;
    localparam logic [2:0] TL_PAD  = 3'd1;
    localparam logic [2:0] TL_FILL = 3'd2;
    localparam logic [2:0] TL_LEN  = 3'd3;
    localparam logic [2:0] TL_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  tail_reg, tail_next;
    logic [3:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] count_reg, count_next;
    vars_t       hash_reg, hash_next;
    vars_t       vars_reg;
    word_t       sched_reg [16];

    logic        push_en;
    word_t       push_word;
    logic [2:0]  vb_clamp;
    word_t       pad_word;
    logic [63:0] bit_len;
    vars_t       vars_rnd;
    word_t       w_new;

    function automatic logic [2:0] dispatch(input logic [2:0] tail);
        unique case (tail)
            TL_NONE: dispatch = ST_IDLE;
            TL_DONE: dispatch = ST_OUT;
            default: dispatch = ST_TAIL;
        endcase
    endfunction

    sha_round u_round (
        .vars     (vars_reg),
        .k        (round_k(rnd_reg)),
        .w0       (sched_reg[0]),
        .w1       (sched_reg[1]),
        .w9       (sched_reg[9]),
        .w14      (sched_reg[14]),
        .vars_new (vars_rnd),
        .w_new    (w_new)
    );

    assign msg.ready          = (state_reg == ST_IDLE);
    assign digest.valid       = (state_reg == ST_OUT);
    assign digest.digest_word = hash_reg[idx_reg];
    assign digest.word_index  = idx_reg;
    assign digest.digest_done = (idx_reg == 3'd7);

    assign bit_len  = {count_reg[60:0], 3'b000};
    assign vb_clamp = (msg.valid_bytes > 3'd4) ? 3'd4 : msg.valid_bytes;

    always_comb
    begin
        case (vb_clamp)
            3'd1:    pad_word = {msg.data_word[31:24], 24'h80_0000};
            3'd2:    pad_word = {msg.data_word[31:16], 16'h8000};
            3'd3:    pad_word = {msg.data_word[31:8], 8'h80};
            default: pad_word = PAD_WORD;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        hash_next  = hash_reg;
        push_en    = 1'b0;
        push_word  = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg.valid)
                begin
                    push_en = 1'b1;
                    if (!msg.end_of_message)
                    begin
                        push_word  = msg.data_word;
                        count_next = count_reg + 64'd4;
                        tail_next  = TL_NONE;
                    end
                    else if (vb_clamp == 3'd4)
                    begin
                        push_word  = msg.data_word;
                        count_next = count_reg + 64'd4;
                        tail_next  = TL_PAD;
                    end
                    else
                    begin
                        push_word  = pad_word;
                        count_next = count_reg + {61'd0, vb_clamp};
                        tail_next  = TL_FILL;
                    end
                end
            end
            ST_TAIL:
            begin
                push_en = 1'b1;
                case (tail_reg)
                    TL_PAD:
                    begin
                        push_word = PAD_WORD;
                        tail_next = TL_FILL;
                    end
                    TL_FILL:
                    begin
                        if (fill_reg == 4'd14)
                        begin
                            push_word = bit_len[63:32];
                            tail_next = TL_LEN;
                        end
                        else
                        begin
                            push_word = '0;
                        end
                    end
                    default:
                    begin
                        push_word = bit_len[31:0];
                        tail_next = TL_DONE;
                    end
                endcase
            end
            ST_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_HADD;
                end
            end
            ST_HADD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + vars_reg[i];
                end
                state_next = dispatch(tail_reg);
            end
            ST_OUT:
            begin
                if (digest.ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        hash_next  = H_INIT;
                        count_next = '0;
                        fill_next  = '0;
                        tail_next  = TL_NONE;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'd15)
            begin
                state_next = ST_ROUND;
                rnd_next   = '0;
            end
            else
            begin
                state_next = dispatch(tail_next);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tail_reg  <= TL_NONE;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
            hash_reg  <= H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            hash_reg  <= hash_next;
        end
    end

    // schedule window: slot 0 holds the word of the current round
    always_ff @(posedge clk)
    begin
        if (push_en || state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= push_en ? push_word : w_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && fill_reg == 4'd15)
        begin
            vars_reg <= hash_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            vars_reg <= vars_rnd;
        end
    end

endmodule

@@ src/sha_checker.sv @@
// Port-level assertions for sha256_stream_hasher, attached by the bind below.
// Depends on the top level's interface ports only.
module sha_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       msg_valid,
    input logic       msg_ready,
    input logic       msg_eom,
    input logic       dg_valid,
    input logic       dg_ready,
    input logic [2:0] dg_index,
    input logic       dg_done
);

    // no message word is taken while digest words are pending
    a_no_intake_on_out: assert property (@(posedge clk) disable iff (!rst_n)
        dg_valid |-> !msg_ready)
        else $error("input ready while digest is output");

    // a word without end of message never starts the digest
    a_no_early_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && !msg_eom) |=> !dg_valid)
        else $error("digest after non-final word");

    // digest words come in order without gaps
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (dg_valid && dg_ready && !dg_done) |=>
            (dg_valid && dg_index == $past(dg_index) + 3'd1))
        else $error("digest word index did not advance");

    // the last digest word ends the output
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (dg_valid && dg_ready && dg_done) |=> !dg_valid)
        else $error("digest continues after last word");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dg_valid && !dg_ready) |=> (dg_valid && $stable(dg_index)))
        else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_eom   (msg.end_of_message),
    .dg_valid  (digest.valid),
    .dg_ready  (digest.ready),
    .dg_index  (digest.word_index),
    .dg_done   (digest.digest_done)
);

@@ tb/sha256_stream_hasher_tb.sv @@
// Self-checking testbench for sha256_stream_hasher: drives message words, predicts digests.
// Depends on sha_pkg, sha_in_if, sha_out_if and the sha256_stream_hasher RTL.
module sha256_stream_hasher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sha_pkg::word_t;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 230;
    localparam int DRAIN_CYCLES = 80;
    localparam int PRESSURE_HOLD = 500;

    localparam word_t SHA_IV [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam word_t SHA_K [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    localparam word_t PAD_MARK = 32'h8000_0000;

    typedef struct packed {
        word_t      digest_word;
        logic [2:0] word_index;
        logic       digest_done;
    } digest_item_t;

    class sha256_predictor;
        word_t          hash_state [8];
        word_t          sched [16];
        bit [63:0]      byte_count;
        bit [3:0]       fill;
        digest_item_t   digest_queue [$];
        int             mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                hash_state[i] = SHA_IV[i];
            byte_count = '0;
            fill = '0;
        endfunction

        function word_t ror(word_t x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            word_t v [8];
            word_t t1;
            word_t t2;
            word_t wa;
            word_t wb;
            for (int i = 0; i < 8; i++)
                v[i] = hash_state[i];
            for (int r = 0; r < 64; r++)
            begin
                if (r >= 16)
                begin
                    wa = sched[(r + 14) & 15];
                    wb = sched[(r + 1) & 15];
                    sched[r & 15] += (ror(wa, 17) ^ ror(wa, 19) ^ (wa >> 10))
                                   + sched[(r + 9) & 15]
                                   + (ror(wb, 7) ^ ror(wb, 18) ^ (wb >> 3));
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + sched[r & 15];
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] += v[i];
        endfunction

        function void load_word(word_t w);
            sched[fill] = w;
            fill = fill + 4'd1;
            if (fill == 4'd0)
                compress();
        endfunction

        // Called for every accepted message word.
        function void absorb_word(word_t data, logic [2:0] vb, logic eom);
            int           nbytes;
            word_t        keep;
            word_t        pad;
            bit [63:0]    bits;
            digest_item_t item;
            if (!eom)
            begin
                byte_count += 64'd4;
                load_word(data);
                return;
            end
            nbytes = (vb > 3'd4) ? 4 : int'(vb);
            byte_count += 64'(nbytes);
            if (nbytes == 4)
            begin
                load_word(data);
                pad = PAD_MARK;
            end
            else if (nbytes == 0)
                pad = PAD_MARK;
            else
            begin
                keep = 32'hFFFF_FFFF << (32 - 8 * nbytes);
                pad = (data & keep) | (32'h80 << (24 - 8 * nbytes));
            end
            load_word(pad);
            // no room left for the length words: flush one extra block
            if (fill > 4'd14)
            begin
                sched[15] = '0;
                compress();
                fill = '0;
            end
            for (int i = int'(fill); i < 14; i++)
                sched[i] = '0;
            bits = byte_count << 3;
            sched[14] = bits[63:32];
            sched[15] = bits[31:0];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                item.digest_word = hash_state[i];
                item.word_index  = 3'(i);
                item.digest_done = (i == 7);
                digest_queue.push_back(item);
            end
            restart();
        endfunction

        task report(string field, logic [31:0] got, logic [31:0] want);
            $display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
            mismatches++;
        endtask

        task check_digest_word(word_t w, logic [2:0] idx, logic done);
            digest_item_t want;
            if (digest_queue.size() == 0)
            begin
                report("digest word with nothing pending", w, '0);
                return;
            end
            want = digest_queue.pop_front();
            if (w !== want.digest_word)
                report("digest_word", w, want.digest_word);
            if (idx !== want.word_index)
                report("word_index", 32'(idx), 32'(want.word_index));
            if (done !== want.digest_done)
                report("digest_done", 32'(done), 32'(want.digest_done));
        endtask
    endclass

    logic clk;
    logic rst_n;

    sha_in_if  msg ();
    sha_out_if digest ();

    sha256_stream_hasher uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .digest (digest)
    );

    sha256_predictor sb = new();
    int words_sent = 0;
    int send_quiet = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, and occasional runs with none.
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input word_t d, input logic [2:0] vb, input logic eom);
        int gap;
        gap = pick_gap(send_quiet);
        if (gap > 0)
        begin
            msg.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg.valid          <= 1'b1;
        msg.data_word      <= d;
        msg.valid_bytes    <= vb;
        msg.end_of_message <= eom;
        do
            @(posedge clk);
        while (!msg.ready);
        sb.absorb_word(d, vb, eom);
        words_sent++;
    endtask

    function automatic word_t rand_data();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    task automatic send_random_message(input int n_words);
        for (int i = 0; i < n_words; i++)
            send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b0);
        send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b1);
    endtask

    // Stimulus and end of run
    initial
    begin
        int r;
        int n_words;
        rst_n              <= 1'b0;
        msg.valid          <= 1'b0;
        msg.data_word      <= '0;
        msg.valid_bytes    <= '0;
        msg.end_of_message <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty message, then "abc"
        send_word(32'h0000_0000, 3'd0, 1'b1);
        send_word(32'h6162_6300, 3'd3, 1'b1);
        // partial final word: trailing bytes must be dropped; 5..7 act as 4
        send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd2, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd5, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd6, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd7, 1'b1);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        // pad marker lands in slot 14: length needs a second block
        for (int i = 0; i < 13; i++)
            send_word(32'hA5A5_0000 + 32'(i), 3'd0, 1'b0);
        send_word(32'h1234_5678, 3'd4, 1'b1);

        while (words_sent < RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                n_words = $urandom_range(0, 18);
            else if (r < 95)
                n_words = $urandom_range(19, 40);
            else
                n_words = $urandom_range(41, 70);
            send_random_message(n_words);
        end
        msg.valid <= 1'b0;

        while (sb.digest_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Digest receiver and checker
    initial
    begin
        int hold;
        int quiet;
        bit pressure_done;
        hold = 0;
        quiet = 0;
        pressure_done = 1'b0;
        digest.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (digest.valid && digest.ready)
                sb.check_digest_word(digest.digest_word, digest.word_index,
                                     digest.digest_done);
            // one long hold-off so the block backs up into its input
            if (!pressure_done && words_sent >= 60 && sb.digest_queue.size() > 0)
            begin
                hold = PRESSURE_HOLD;
                pressure_done = 1'b1;
            end
            else if (hold == 0)
                hold = pick_gap(quiet);
            if (hold > 0)
            begin
                digest.ready <= 1'b0;
                hold--;
            end
            else
                digest.ready <= 1'b1;
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sha256_stream_hasher.f @@
src/sha_pkg.sv
src/sha_in_if.sv
src/sha_out_if.sv
src/sha_round.sv
src/sha256_stream_hasher.sv
src/sha_checker.sv
tb/sha256_stream_hasher_tb.sv
